// ===== rtl/stack_language_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Stack language tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_LANGUAGE_TOKENIZER_MACROS_SVH
`define STACK_LANGUAGE_TOKENIZER_MACROS_SVH

// Property checked at every clock edge outside reset
`define SLT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication into the following cycle
`define SLT_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack language tokenizer package
// Token kinds, lexer modes, character codes, result type and class helpers.
// ----------------------------------------------------------------------------
package slt_pkg;

   typedef logic [3:0] kind_type;
   typedef logic [1:0] mode_type;

   // Token kinds
   localparam kind_type KIND_EOF  = 4'd0;
   localparam kind_type KIND_ADD  = 4'd1;
   localparam kind_type KIND_SUB  = 4'd2;
   localparam kind_type KIND_IDIV = 4'd3;
   localparam kind_type KIND_IMUL = 4'd4;
   localparam kind_type KIND_UDIV = 4'd5;
   localparam kind_type KIND_UMUL = 4'd6;
   localparam kind_type KIND_WORD = 4'd7;
   localparam kind_type KIND_INT  = 4'd8;
   localparam kind_type KIND_PUTI = 4'd9;

   // Lexer modes
   localparam mode_type MODE_TRIM    = 2'd0;
   localparam mode_type MODE_WORD    = 2'd1;
   localparam mode_type MODE_INT     = 2'd2;
   localparam mode_type MODE_COMMENT = 2'd3;

   // Character codes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Keyword spellings, first letter in the top byte
   localparam logic [31:0] KW_IDIV = 32'h69646976;
   localparam logic [31:0] KW_IMUL = 32'h696D756C;
   localparam logic [31:0] KW_UDIV = 32'h75646976;
   localparam logic [31:0] KW_UMUL = 32'h756D756C;
   localparam logic [31:0] KW_PUTI = 32'h70757469;

   // One result transaction
   typedef struct packed {
      kind_type           kind;
      logic [31:0]        start_offset;
      logic [15:0]        word_length;
      logic signed [63:0] int_value;
      logic               last;
   } rsp_item_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
   endfunction

   function automatic logic breaks_word(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || is_space(c);
   endfunction

   // Keyword match; only four-letter words qualify
   function automatic kind_type word_kind(input logic is_four, input logic [31:0] chars);
      kind_type k;
      k = KIND_WORD;
      if (is_four) begin
         if (chars == KW_IDIV)      k = KIND_IDIV;
         else if (chars == KW_IMUL) k = KIND_IMUL;
         else if (chars == KW_UDIV) k = KIND_UDIV;
         else if (chars == KW_UMUL) k = KIND_UMUL;
         else if (chars == KW_PUTI) k = KIND_PUTI;
      end
      return k;
   endfunction

endpackage

// ===== rtl/stack_language_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Stack language tokenizer: classifies each held byte against the next byte as lookahead.
// Throughput one byte per cycle while the result queue has room (req_stall); an end marker yields up to two tokens.
// Reset (synchronous) empties the result queue and starts a stream at 0.
// ----------------------------------------------------------------------------
`include "stack_language_tokenizer_macros.svh"

module stack_language_tokenizer
   import slt_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_at_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_kind,
   output logic [31:0]        rsp_start_offset,
   output logic [15:0]        rsp_word_length,
   output logic signed [63:0] rsp_int_value,
   output logic               rsp_last
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN_FOUR = LENGTH_BITS'(4);

   // Lexer state
   mode_type               mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   neg_ff, neg_in;
   logic [63:0]            acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [31:0]            first_ff, first_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] tstart_ff, tstart_in;

   // Result queue, four entries
   rsp_item_type q_ff [4];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   cnt_ff, cnt_in;

   logic                   accept, pop;
   logic [OFFSET_BITS-1:0] idx;
   logic                   p_digit, p_break, proceed;
   mode_type               mode_v;
   logic                   neg_v;
   logic [63:0]            acc_v, acc_x10;
   logic [LENGTH_BITS-1:0] len_v;
   logic [31:0]            first_v, len_wide;
   logic [OFFSET_BITS-1:0] tstart_v;
   logic [7:0]             digit;
   logic                   emit;
   rsp_item_type           item0, item1, push_a_item;
   logic                   push_a, push_b;

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = cnt_ff > 3'd2;
   assign rsp_valid = cnt_ff != 3'd0;

   assign idx     = pos_ff - OFFSET_BITS'(1);
   assign p_digit = !req_at_end && is_digit(req_in_byte);
   assign p_break = req_at_end || breaks_word(req_in_byte);
   assign digit   = held_ff - CH_ZERO;

   // Classify the held byte against the incoming lookahead
   always_comb begin
      mode_v   = mode_ff;
      neg_v    = neg_ff;
      acc_v    = acc_ff;
      len_v    = len_ff;
      first_v  = first_ff;
      tstart_v = tstart_ff;
      emit     = 1'b0;
      proceed  = 1'b1;
      acc_x10  = '0;
      len_wide = '0;
      item0    = '0;
      item0.last = !req_at_end;

      if (held_valid_ff) begin
         if (mode_v == MODE_TRIM) begin
            proceed = 1'b0;
            if (held_ff == CH_PLUS) begin
               emit               = 1'b1;
               item0.kind         = KIND_ADD;
               item0.start_offset = 32'(idx);
            end else if (held_ff == CH_MINUS) begin
               if (!p_digit) begin
                  emit               = 1'b1;
                  item0.kind         = KIND_SUB;
                  item0.start_offset = 32'(idx);
               end else begin
                  neg_v    = 1'b1;
                  acc_v    = '0;
                  tstart_v = idx;
                  mode_v   = MODE_INT;
               end
            end else if (held_ff == CH_SLASH && !req_at_end && req_in_byte == CH_SLASH) begin
               mode_v = MODE_COMMENT;
            end else if (!is_space(held_ff)) begin
               proceed  = 1'b1;
               tstart_v = idx;
               if (is_digit(held_ff)) begin
                  neg_v  = 1'b0;
                  acc_v  = '0;
                  mode_v = MODE_INT;
               end else begin
                  len_v   = '0;
                  first_v = '0;
                  mode_v  = MODE_WORD;
               end
            end
         end

         if (proceed) begin
            unique case (mode_v)
               MODE_WORD: begin
                  if (len_v < LEN_FOUR) first_v = {first_v[23:0], held_ff};
                  if (len_v < LEN_MAX) len_v = len_v + LENGTH_BITS'(1);
                  if (p_break) begin
                     len_wide           = 32'(len_v);
                     emit               = 1'b1;
                     item0.kind         = word_kind(len_v == LEN_FOUR, first_v);
                     item0.start_offset = 32'(tstart_v);
                     item0.word_length  = (len_wide > 32'h0000FFFF) ? 16'hFFFF
                                                                    : len_wide[15:0];
                     mode_v             = MODE_TRIM;
                  end
               end
               MODE_INT: begin
                  // Negative values accumulate already negated
                  acc_x10 = {acc_v[60:0], 3'b000} + {acc_v[62:0], 1'b0};
                  acc_v   = neg_v ? (acc_x10 - 64'(digit)) : (acc_x10 + 64'(digit));
                  if (!p_digit) begin
                     emit               = 1'b1;
                     item0.kind         = KIND_INT;
                     item0.start_offset = 32'(tstart_v);
                     item0.int_value    = acc_v;
                     mode_v             = MODE_TRIM;
                  end
               end
               MODE_COMMENT: begin
                  if (held_ff == CH_LF) mode_v = MODE_TRIM;
               end
               default: ;
            endcase
         end
      end
   end

   // End-of-stream token
   always_comb begin
      item1              = '0;
      item1.kind         = KIND_EOF;
      item1.start_offset = 32'(pos_ff);
      item1.last         = 1'b1;
   end

   // Next lexer state; the end marker starts a fresh stream
   always_comb begin
      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      first_in      = first_ff;
      pos_in        = pos_ff;
      tstart_in     = tstart_ff;
      if (accept) begin
         if (req_at_end) begin
            mode_in       = MODE_TRIM;
            held_in       = '0;
            held_valid_in = 1'b0;
            neg_in        = 1'b0;
            acc_in        = '0;
            len_in        = '0;
            first_in      = '0;
            pos_in        = '0;
            tstart_in     = '0;
         end else begin
            mode_in       = mode_v;
            held_in       = req_in_byte;
            held_valid_in = 1'b1;
            neg_in        = neg_v;
            acc_in        = acc_v;
            len_in        = len_v;
            first_in      = first_v;
            pos_in        = pos_ff + OFFSET_BITS'(1);
            tstart_in     = tstart_v;
         end
      end
   end

   // Queue pushes: classified token first, then the end token
   assign push_a      = accept && (emit || req_at_end);
   assign push_b      = accept && emit && req_at_end;
   assign push_a_item = emit ? item0 : item1;
   assign cnt_in      = cnt_ff + 3'(push_a) + 3'(push_b) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TRIM;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         neg_ff        <= 1'b0;
         acc_ff        <= '0;
         len_ff        <= '0;
         first_ff      <= '0;
         pos_ff        <= '0;
         tstart_ff     <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         cnt_ff        <= '0;
      end else begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         neg_ff        <= neg_in;
         acc_ff        <= acc_in;
         len_ff        <= len_in;
         first_ff      <= first_in;
         pos_ff        <= pos_in;
         tstart_ff     <= tstart_in;
         wr_ptr_ff     <= wr_ptr_ff + 2'(push_a) + 2'(push_b);
         if (pop) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         cnt_ff        <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_a) q_ff[wr_ptr_ff] <= push_a_item;
      if (push_b) q_ff[wr_ptr_ff + 2'd1] <= item1;
   end

   assign rsp_kind         = q_ff[rd_ptr_ff].kind;
   assign rsp_start_offset = q_ff[rd_ptr_ff].start_offset;
   assign rsp_word_length  = q_ff[rd_ptr_ff].word_length;
   assign rsp_int_value    = q_ff[rd_ptr_ff].int_value;
   assign rsp_last         = q_ff[rd_ptr_ff].last;

   // Checks
   `SLT_ASSERT(a_cnt_bound, cnt_ff <= 3'd4, "result queue overfilled")
   `SLT_ASSERT_NEXT(a_end_clears, accept && req_at_end,
      !held_valid_ff && pos_ff == '0 && mode_ff == MODE_TRIM, "end marker did not restart stream")
   `SLT_ASSERT_NEXT(a_byte_held, accept && !req_at_end,
      held_valid_ff && held_ff == $past(req_in_byte), "accepted byte not held")
   `SLT_ASSERT_NEXT(a_cnt_idle, !accept && !pop, $stable(cnt_ff),
      "queue count moved without a transaction")

endmodule

// ===== dv/stack_language_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// Stack language tokenizer testbench
// Feeds byte streams with end markers into the tokenizer under random idling
// on both channels and checks every token against an in-bench lexer that
// tracks the same lookahead state, in order, field by field.
// ----------------------------------------------------------------------------
module stack_language_tokenizer_test;
   import slt_pkg::*;

   localparam int RANDOM_BYTES = 1500;
   localparam int HOLD_OFF     = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_WORD    = 40;

   // Lexer that predicts the token stream
   class token_scoreboard;
      mode_type     mode;
      logic [7:0]   held;
      bit           held_ok;
      bit           neg;
      logic [63:0]  acc;
      logic [15:0]  len_count;
      logic [31:0]  head_chars;
      logic [31:0]  pos;
      logic [31:0]  tok_start;
      rsp_item_type expected_tokens[$];
      rsp_item_type step_tokens[$];
      int           mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         mode       = MODE_TRIM;
         held       = 8'h00;
         held_ok    = 0;
         neg        = 0;
         acc        = 64'd0;
         len_count  = 16'd0;
         head_chars = 32'd0;
         pos        = 32'd0;
         tok_start  = 32'd0;
      endfunction

      function void emit(kind_type k, logic [31:0] s, logic [15:0] l, logic [63:0] v);
         rsp_item_type t;
         t.kind         = k;
         t.start_offset = s;
         t.word_length  = l;
         t.int_value    = v;
         t.last         = 1'b0;
         step_tokens.push_back(t);
      endfunction

      // Classify byte c at index idx, looking ahead at p (or the end marker)
      function void classify(logic [7:0] c, logic [31:0] idx, logic [7:0] p, bit at_end);
         bit         p_digit;
         bit         p_break;
         kind_type   k;
         logic [7:0] digit;
         p_digit = !at_end && (p >= CH_ZERO) && (p <= CH_NINE);
         p_break = at_end || p == CH_PLUS || p == CH_MINUS || p == CH_SPACE
                   || p == CH_TAB || p == CH_LF;

         if (mode == MODE_TRIM) begin
            if (c == CH_PLUS) begin
               emit(KIND_ADD, idx, 16'd0, 64'd0);
               return;
            end
            if (c == CH_MINUS) begin
               if (!p_digit) begin
                  emit(KIND_SUB, idx, 16'd0, 64'd0);
               end else begin
                  neg       = 1;
                  acc       = 64'd0;
                  tok_start = idx;
                  mode      = MODE_INT;
               end
               return;
            end
            if (c == CH_SLASH && !at_end && p == CH_SLASH) begin
               mode = MODE_COMMENT;
               return;
            end
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF)
               return;
            tok_start = idx;
            if (c >= CH_ZERO && c <= CH_NINE) begin
               neg  = 0;
               acc  = 64'd0;
               mode = MODE_INT;
            end else begin
               len_count  = 16'd0;
               head_chars = 32'd0;
               mode       = MODE_WORD;
            end
         end

         if (mode == MODE_WORD) begin
            if (len_count < 16'd4)
               head_chars = {head_chars[23:0], c};
            if (len_count != 16'hFFFF)
               len_count = len_count + 16'd1;
            if (p_break) begin
               k = KIND_WORD;
               // only exact four-letter words are keywords
               if (len_count == 16'd4) begin
                  case (head_chars)
                     KW_IDIV: k = KIND_IDIV;
                     KW_IMUL: k = KIND_IMUL;
                     KW_UDIV: k = KIND_UDIV;
                     KW_UMUL: k = KIND_UMUL;
                     KW_PUTI: k = KIND_PUTI;
                     default: k = KIND_WORD;
                  endcase
               end
               emit(k, tok_start, len_count, 64'd0);
               mode = MODE_TRIM;
            end
         end else if (mode == MODE_INT) begin
            digit = c - CH_ZERO;
            acc   = acc * 64'd10 + {56'd0, digit};
            if (!p_digit) begin
               emit(KIND_INT, tok_start, 16'd0, neg ? 64'd0 - acc : acc);
               mode = MODE_TRIM;
            end
         end else if (mode == MODE_COMMENT) begin
            if (c == CH_LF)
               mode = MODE_TRIM;
         end
      endfunction

      // One accepted byte transaction
      function void note_request(logic [7:0] b, logic e);
         logic [31:0]  idx;
         rsp_item_type t;
         idx = pos - 32'd1;
         step_tokens.delete();
         if (e) begin
            if (held_ok)
               classify(held, idx, 8'h00, 1);
            emit(KIND_EOF, pos, 16'd0, 64'd0);
            restart();
         end else begin
            if (held_ok)
               classify(held, idx, b, 0);
            held    = b;
            held_ok = 1;
            pos     = pos + 32'd1;
         end
         foreach (step_tokens[i]) begin
            t      = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
         end
      endfunction

      // One accepted token transaction
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token: kind %0d start %0d len %0d value %0d last %0b",
                        got.kind, got.start_offset, got.word_length, got.int_value, got.last);
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.start_offset !== want.start_offset
             || got.word_length !== want.word_length || got.int_value !== want.int_value
             || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("token mismatch: expected kind %0d start %0d len %0d value %0d last %0b",
                        want.kind, want.start_offset, want.word_length, want.int_value,
                        want.last);
               $display("                actual   kind %0d start %0d len %0d value %0d last %0b",
                        got.kind, got.start_offset, got.word_length, got.int_value, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_in_byte;
   logic               req_at_end;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [3:0]         rsp_kind;
   logic [31:0]        rsp_start_offset;
   logic [15:0]        rsp_word_length;
   logic signed [63:0] rsp_int_value;
   logic               rsp_last;

   token_scoreboard sb;
   bit              hold_off_wanted;
   bit              sender_steady;
   int              bytes_sent;
   int              idle_cycles;

   stack_language_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_at_end       (req_at_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_word_length  (rsp_word_length),
      .rsp_int_value    (rsp_int_value),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one byte transaction and wait for it to be taken
   task automatic send_byte(input logic [7:0] b, input logic e);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_at_end  <= e;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // One stream of mostly well-formed tokens with random content
   task automatic random_stream();
      logic [7:0]  text[$];
      logic [31:0] keywords[5];
      logic [31:0] kw;
      int          n_tokens;
      int          r;
      int          n;
      keywords = '{KW_IDIV, KW_IMUL, KW_UDIV, KW_UMUL, KW_PUTI};
      n_tokens = $urandom_range(0, 8);
      for (int t = 0; t < n_tokens; t++) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            text.push_back(CH_PLUS);
         end else if (r < 18) begin
            text.push_back(CH_MINUS);
         end else if (r < 40) begin
            // integer, sometimes long enough to wrap
            if ($urandom_range(0, 1)) text.push_back(CH_MINUS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 6);
            repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         end else if (r < 70) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               kw = keywords[$urandom_range(0, 4)];
               if (r >= 30 && r < 35) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
               text.push_back(kw[31:24]);
               text.push_back(kw[23:16]);
               text.push_back(kw[15:8]);
               text.push_back(kw[7:0]);
               if (r >= 35) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end else begin
               n = $urandom_range(1, 8);
               for (int i = 0; i < n; i++) begin
                  r = $urandom_range(0, 9);
                  if (r < 7)       text.push_back(8'($urandom_range(8'h61, 8'h7A)));
                  else if (r == 7) text.push_back(CH_SLASH);
                  else if (r == 8) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                  else             text.push_back(8'($urandom_range(0, 255)));
               end
            end
         end else if (r < 80) begin
            // comment, usually closed by a newline
            text.push_back(CH_SLASH);
            text.push_back(CH_SLASH);
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) text.push_back(CH_LF);
         end else if (r < 90) begin
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
         end
         // separator, or none to run tokens together
         if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 3)) begin
               r = $urandom_range(0, 2);
               text.push_back(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_LF));
            end
         end
      end
      foreach (text[i])
         send_byte(text[i], 1'b0);
      send_end();
   endtask

   // Receiver: random stalls, quiet stretches and one long hold-off
   initial begin
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
            hold_off_wanted = 0;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(40, 150)) @(posedge clock);
            end else begin
               repeat ($urandom_range(1, 20)) @(posedge clock);
               n_stall_gap();
            end
         end
      end
   end

   task automatic n_stall_gap();
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         rsp_stall <= 1'b1;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Monitor both channels and watch for a hang
   always @(posedge clock) begin
      rsp_item_type got;
      bit           moved;
      if (!reset) begin
         moved = 0;
         if (req_valid && !req_stall) begin
            sb.note_request(req_in_byte, req_at_end);
            moved = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind         = rsp_kind;
            got.start_offset = rsp_start_offset;
            got.word_length  = rsp_word_length;
            got.int_value    = rsp_int_value;
            got.last         = rsp_last;
            sb.check_result(got);
            moved = 1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("stack_language_tokenizer_test failed");
            $finish;
         end
      end
   end

   initial begin
      sb              = new();
      hold_off_wanted = 0;
      sender_steady   = 0;
      bytes_sent      = 0;
      idle_cycles     = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_in_byte     = 8'h00;
      req_at_end      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: add, negative int, sub before a comment, closed comment
      send_text("+-7 -//c\n");
      send_end();
      // slash and zero byte inside a word, word running into the end marker
      send_text("a/b");
      send_byte(8'h00, 1'b0);
      send_end();
      // sub at end, unterminated comment, keyword at end, high byte word
      send_text("-");
      send_end();
      send_text("//");
      send_end();
      send_text("puti");
      send_end();
      send_byte(8'hFF, 1'b0);
      send_end();

      // Random streams; the receiver holds off early so the block backs up
      hold_off_wanted = 1;
      bytes_sent      = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         sender_steady = ($urandom_range(0, 4) == 0);
         random_stream();
      end

      // Integer extremes and 64-bit wrap, then a long word that opens like a keyword
      sender_steady = 0;
      send_text("9223372036854775807 -9223372036854775808 18446744073709551617");
      send_end();
      sender_steady = 1;
      send_text("idiv");
      repeat (LONG_WORD - 4) send_byte("z", 1'b0);
      send_end();
      sender_steady = 0;
      req_valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("stack_language_tokenizer_test passed");
      else
         $display("stack_language_tokenizer_test failed");
      $finish;
   end

endmodule

// ===== stack_language_tokenizer.f =====
+incdir+rtl
rtl/slt_pkg.sv
rtl/stack_language_tokenizer.sv
dv/stack_language_tokenizer_test.sv
